>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> src/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared constants, codes and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

    localparam int NUM_ORDERS_DEF = 8;
    localparam int BASE_ORDER_DEF = 12;
    localparam int ADDR_W         = 48;
    localparam int TOP_W          = 3;
    localparam int ORDER_W        = 4;
    localparam int TOP_ORDER_RST  = 7;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_REINIT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [1:0] ST_BAD_ORD  = 2'd2;
    localparam logic [1:0] ST_NULL     = 2'd3;

    localparam logic CFG_ARENA_BASE = 1'b0;
    localparam logic CFG_TOP_ORDER  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_SPLIT,
        S_MERGE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       cur_inc;
        logic       take;
        logic       split;
        logic       check;
        logic       merge;
        logic       set_bit;
        logic       reinit;
        logic       finish;
        logic       with_addr;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       ord_bad;
        logic       addr_null;
        logic       found;
        logic       cur_top;
        logic       cur_gt_ord;
        logic       in_range;
        logic       buddy_free;
    } sts_t;

endpackage

>>> src/bba_datapath.sv
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Per-order free bitmaps, request registers, index walk and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_datapath #(
    parameter int NUM_ORDERS = bba_pkg::NUM_ORDERS_DEF,
    parameter int BASE_ORDER = bba_pkg::BASE_ORDER_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [bba_pkg::ADDR_W-1:0] cfg_data,
    input  logic [1:0]                in_req,
    input  logic [bba_pkg::ORDER_W-1:0] in_order,
    input  logic [bba_pkg::ADDR_W-1:0] in_addr,
    input  bba_pkg::cmd_t             cmd,
    output bba_pkg::sts_t             sts,
    output logic [bba_pkg::ADDR_W-1:0] res_addr,
    output logic [1:0]                res_status
);

    localparam int ORD_W   = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int IDX_W   = (NUM_ORDERS > 1) ? NUM_ORDERS - 1 : 1;
    localparam int BLK_MAX = 2 ** (NUM_ORDERS - 1);
    localparam int RST_TOP = (bba_pkg::TOP_ORDER_RST < NUM_ORDERS) ?
                             bba_pkg::TOP_ORDER_RST : NUM_ORDERS - 1;

    logic [bba_pkg::ADDR_W-1:0]  base_reg;
    logic [bba_pkg::TOP_W-1:0]   top_reg;
    logic [1:0]                  req_reg;
    logic [bba_pkg::ORDER_W-1:0] ord_reg;
    logic                        null_reg;
    logic [bba_pkg::ADDR_W-1:0]  diff_reg;
    logic [ORD_W-1:0]            cur_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [BLK_MAX-1:0]          row_reg [NUM_ORDERS];
    logic [bba_pkg::ADDR_W-1:0]  res_addr_reg;
    logic [1:0]                  status_reg;

    logic [BLK_MAX-1:0]          row_cur;
    logic [IDX_W-1:0]            low_idx;
    logic [IDX_W-1:0]            buddy;
    logic [IDX_W-1:0]            idx_dbl;
    logic [ORD_W-1:0]            cur_dn;
    logic [ORD_W-1:0]            reinit_ord;
    logic [5:0]                  shamt;
    logic [bba_pkg::ADDR_W-1:0]  shifted;
    logic [4:0]                  span;
    logic [bba_pkg::ADDR_W-1:0]  alloc_addr;

    assign row_cur = row_reg[cur_reg];
    assign buddy   = idx_reg ^ IDX_W'(1);
    assign idx_dbl = idx_reg << 1;
    assign cur_dn  = cur_reg - ORD_W'(1);
    assign shamt   = 6'(ord_reg) + 6'(BASE_ORDER);
    assign shifted = diff_reg >> shamt;
    assign span    = 5'(NUM_ORDERS - 1) - 5'(ord_reg);
    assign alloc_addr = base_reg + (bba_pkg::ADDR_W'(idx_reg) << shamt);

    // Lowest free block of the current order.
    always_comb begin
        low_idx = '0;
        for (int i = BLK_MAX - 1; i >= 0; i--) begin
            if (row_cur[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (5'(top_reg) >= 5'(NUM_ORDERS)) begin
            reinit_ord = ORD_W'(NUM_ORDERS - 1);
        end else begin
            reinit_ord = ORD_W'(top_reg);
        end
    end

    always_comb begin
        sts.req        = req_reg;
        sts.ord_bad    = 5'(ord_reg) >= 5'(NUM_ORDERS);
        sts.addr_null  = null_reg;
        sts.found      = |row_cur;
        sts.cur_top    = cur_reg == ORD_W'(NUM_ORDERS - 1);
        sts.cur_gt_ord = 5'(cur_reg) > 5'(ord_reg);
        sts.in_range   = (shifted >> span) == '0;
        sts.buddy_free = row_cur[buddy];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            top_reg  <= bba_pkg::TOP_W'(bba_pkg::TOP_ORDER_RST);
        end else if (cfg_we) begin
            if (cfg_index == bba_pkg::CFG_ARENA_BASE) begin
                base_reg <= cfg_data;
            end else begin
                top_reg <= cfg_data[bba_pkg::TOP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= in_req;
            ord_reg  <= in_order;
            null_reg <= in_addr == '0;
            diff_reg <= in_addr - base_reg;
            cur_reg  <= in_order[ORD_W-1:0];
        end
        if (cmd.cur_inc) begin
            cur_reg <= cur_reg + ORD_W'(1);
        end
        if (cmd.take) begin
            idx_reg <= low_idx;
        end
        if (cmd.split) begin
            cur_reg <= cur_dn;
            idx_reg <= idx_dbl;
        end
        if (cmd.check) begin
            idx_reg <= shifted[IDX_W-1:0];
        end
        if (cmd.merge) begin
            cur_reg <= cur_reg + ORD_W'(1);
            idx_reg <= idx_reg >> 1;
        end
        if (cmd.finish) begin
            status_reg   <= cmd.status;
            res_addr_reg <= cmd.with_addr ? alloc_addr : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int o = 0; o < NUM_ORDERS; o++) begin
                row_reg[o] <= '0;
            end
            row_reg[RST_TOP][0] <= 1'b1;
        end else if (cmd.reinit) begin
            for (int o = 0; o < NUM_ORDERS; o++) begin
                row_reg[o] <= '0;
            end
            row_reg[reinit_ord][0] <= 1'b1;
        end else begin
            if (cmd.take) begin
                row_reg[cur_reg][low_idx] <= 1'b0;
            end
            if (cmd.split) begin
                row_reg[cur_dn][idx_dbl]          <= 1'b0;
                row_reg[cur_dn][idx_dbl | IDX_W'(1)] <= 1'b1;
            end
            if (cmd.merge) begin
                row_reg[cur_reg][idx_reg] <= 1'b0;
                row_reg[cur_reg][buddy]   <= 1'b0;
            end
            if (cmd.set_bit) begin
                row_reg[cur_reg][idx_reg] <= 1'b1;
            end
        end
    end

    assign res_addr   = res_addr_reg;
    assign res_status = status_reg;

endmodule

>>> src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences search, split and merge steps and owns the stream handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);

    bba_pkg::state_t state_reg, state_next;
    logic            out_valid_reg;
    logic            slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::S_IDLE: begin
                if (s_tvalid && slot_free) begin
                    state_next = bba_pkg::S_DISPATCH;
                end
            end
            bba_pkg::S_DISPATCH: begin
                state_next = bba_pkg::S_IDLE;
                if (sts.req == bba_pkg::REQ_ALLOC && !sts.ord_bad) begin
                    state_next = bba_pkg::S_SEARCH;
                end else if (sts.req == bba_pkg::REQ_FREE && !sts.addr_null &&
                             !sts.ord_bad && sts.in_range) begin
                    state_next = bba_pkg::S_MERGE;
                end
            end
            bba_pkg::S_SEARCH: begin
                if (sts.found) begin
                    state_next = bba_pkg::S_SPLIT;
                end else if (sts.cur_top) begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_SPLIT: begin
                if (!sts.cur_gt_ord) begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_MERGE: begin
                if (sts.cur_top || !sts.buddy_free) begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default: state_next = bba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            bba_pkg::S_IDLE: begin
                s_tready = slot_free;
                cmd.load = s_tvalid && slot_free;
            end
            bba_pkg::S_DISPATCH: begin
                if (sts.req == bba_pkg::REQ_ALLOC) begin
                    if (sts.ord_bad) begin
                        cmd.finish = 1'b1;
                        cmd.status = bba_pkg::ST_BAD_ORD;
                    end
                end else if (sts.req == bba_pkg::REQ_FREE) begin
                    if (sts.addr_null) begin
                        cmd.finish = 1'b1;
                        cmd.status = bba_pkg::ST_NULL;
                    end else if (sts.ord_bad || !sts.in_range) begin
                        cmd.finish = 1'b1;
                        cmd.status = bba_pkg::ST_BAD_ORD;
                    end else begin
                        cmd.check = 1'b1;
                    end
                end else if (sts.req == bba_pkg::REQ_REINIT) begin
                    cmd.reinit = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.status = bba_pkg::ST_OK;
                end else begin
                    cmd.finish = 1'b1;
                    cmd.status = bba_pkg::ST_BAD_ORD;
                end
            end
            bba_pkg::S_SEARCH: begin
                if (sts.found) begin
                    cmd.take = 1'b1;
                end else if (sts.cur_top) begin
                    cmd.finish = 1'b1;
                    cmd.status = bba_pkg::ST_NO_BLOCK;
                end else begin
                    cmd.cur_inc = 1'b1;
                end
            end
            bba_pkg::S_SPLIT: begin
                if (sts.cur_gt_ord) begin
                    cmd.split = 1'b1;
                end else begin
                    cmd.finish    = 1'b1;
                    cmd.with_addr = 1'b1;
                    cmd.status    = bba_pkg::ST_OK;
                end
            end
            bba_pkg::S_MERGE: begin
                if (!sts.cur_top && sts.buddy_free) begin
                    cmd.merge = 1'b1;
                end else begin
                    cmd.set_bit = 1'b1;
                    cmd.finish  = 1'b1;
                    cmd.status  = bba_pkg::ST_OK;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bba_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> src/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over one arena with per-order free bitmaps.
// ----------------------------------------------------------------------------
// One request is in flight at a time; each beat on the input gives exactly one
// result beat. A request is accepted in the idle state and then dispatched. An
// allocate then searches the order rows upward from the requested order, up to
// at most the top order, and splits the found block back down to the requested
// order. A free merges upward while the buddy is free and below the top order,
// then sets the bit of the merged block. Reinit and rejected requests finish at
// dispatch. The step loop of the controller over the per-order bitmap rows sets
// these steps. A new request is taken as soon as the block is idle and the result
// register is empty or being drained in the same cycle. Configuration writes
// are always accepted and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buddy_block_allocator #(
    parameter int NUM_ORDERS = bba_pkg::NUM_ORDERS_DEF,
    parameter int BASE_ORDER = bba_pkg::BASE_ORDER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // req_type[1:0], order[5:2], addr[53:6], zero pad
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // result_addr[47:0], status[49:48], zero pad
);

    bba_pkg::cmd_t cmd;
    bba_pkg::sts_t sts;
    logic [bba_pkg::ADDR_W-1:0] res_addr;
    logic [1:0]                 res_status;

    // Registers are never busy; accept every write beat.
    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_datapath #(
        .NUM_ORDERS (NUM_ORDERS),
        .BASE_ORDER (BASE_ORDER)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_req     (s_tdata[1:0]),
        .in_order   (s_tdata[5:2]),
        .in_addr    (s_tdata[53:6]),
        .cmd        (cmd),
        .sts        (sts),
        .res_addr   (res_addr),
        .res_status (res_status)
    );

    // Pack the result beat, status above the address.
    assign m_tdata = {6'b0, res_status, res_addr};

endmodule

>>> src/bba_checker.sv
// ----------------------------------------------------------------------------
// Buddy allocator port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // A held result stays until taken.
    `ASSERT_RUN(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    // Only a successful answer carries an address.
    `ASSERT_RUN(a_addr_zero, m_tvalid && m_tdata[49:48] != bba_pkg::ST_OK |-> m_tdata[47:0] == 48'd0, "address on error")
    // One request at a time: busy right after accepting.
    `ASSERT_RUN(a_busy, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
    // Reset empties the result register.
    `ASSERT_ALWAYS(a_rst_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
